/* sv/ilc_pkg.sv */
// Shared types, widths and constants of the intensity linearization curve.
// Depends on nothing; every other file imports it.
package ilc_pkg;

   localparam int VW   = 43;  // log2 operand width
   localparam int LGW  = 32;  // log2 result, signed Q.24
   localparam int TW   = 40;  // exp2 operand, signed Q.24
   localparam int NW   = TW - 24;
   localparam int EW   = 41;  // exp2 result, unsigned Q.32
   localparam int YW   = 62;  // final product, Q.48
   localparam int FRAC_STEPS = 24;
   localparam int NORM_STEPS = 6;
   localparam logic [5:0] FB_WIDE = 6'd32;

   localparam logic [2:0] MODE_GAMMA = 3'd0;
   localparam logic [2:0] MODE_SEP   = 3'd1;
   localparam logic [2:0] MODE_LOC   = 3'd2;
   localparam logic [2:0] MODE_REV0  = 3'd3;
   localparam logic [2:0] MODE_REV1  = 3'd4;

   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_GAMMA = 2'd1;
   localparam logic [1:0] REG_GAIN  = 2'd2;

   localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
   localparam logic [23:0] LN2_Q24   = 24'd11629080;
   localparam logic [19:0] C_SEP  = 20'd15729;
   localparam logic [19:0] C_LOC  = 20'd9916;
   localparam logic [19:0] A_REV0 = 20'd95683;
   localparam logic [19:0] A_REV1 = 20'd85197;
   localparam logic [23:0] E_SEP  = 24'd342753;
   localparam logic [23:0] E_LOC  = 24'd336960;
   localparam logic [23:0] B_REV0 = 24'd13763;
   localparam logic [23:0] B_REV1 = 24'd13107;

   typedef struct packed {
      logic signed [7:0] ip;
      logic [31:0]       m;
      logic [23:0]       frac;
   } lg_word_type;

   typedef struct packed {
      logic signed [NW-1:0] n;
      logic [23:0]          f;
      logic [31:0]          r;
   } ex_word_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bit_v;
      rem   = x;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bit_v) begin
            rem = rem - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 2^k-th root of two (2^(2^-k)) in Q1.30, as the chain of square roots
   function automatic logic [30:0] ex_root(input int k);
      logic [63:0] c;
      c = isqrt64(64'd1 << 61);
      for (int j = 2; j <= k; j++) begin
         c = isqrt64(c << 30);
      end
      return c[30:0];
   endfunction

endpackage

/* sv/ilc_lg_cell.sv */
// One squaring step of the base-2 logarithm: emits one fraction bit.
// Depends on ilc_pkg.
module ilc_lg_cell #(
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  ilc_pkg::lg_word_type in_word,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output ilc_pkg::lg_word_type out_word,
   output logic [SIDE_W-1:0]   out_side
);
   import ilc_pkg::*;

   logic [63:0]  sq;
   logic [32:0]  sh;
   lg_word_type  word_in, word_ff;
   logic [SIDE_W-1:0] side_ff;
   logic         valid_ff;

   always_comb begin
      sq = 64'(in_word.m) * 64'(in_word.m);
      sh = sq[63:31];
      word_in    = in_word;
      if (sh[32]) begin
         word_in.m    = sh[32:1];
         word_in.frac = {in_word.frac[22:0], 1'b1};
      end else begin
         word_in.m    = sh[31:0];
         word_in.frac = {in_word.frac[22:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_side  = side_ff;
endmodule

/* sv/ilc_ex_cell.sv */
// One root-of-two multiply step of the base-2 exponential.
// Depends on ilc_pkg.
module ilc_ex_cell #(
   parameter int K = 1,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  ilc_pkg::ex_word_type in_word,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output ilc_pkg::ex_word_type out_word,
   output logic [SIDE_W-1:0]   out_side
);
   import ilc_pkg::*;

   localparam logic [30:0] ROOT = ex_root(K);

   logic [62:0]  prod;
   ex_word_type  word_in, word_ff;
   logic [SIDE_W-1:0] side_ff;
   logic         valid_ff;

   always_comb begin
      prod    = 63'(in_word.r) * 63'(ROOT) + (63'd1 << 29);
      word_in = in_word;
      if (in_word.f[24-K]) begin
         word_in.r = prod[61:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_side  = side_ff;
endmodule

/* sv/ilc_lg.sv */
// Base-2 logarithm unit: staged normalize, then a chain of squaring cells.
// Depends on ilc_pkg and ilc_lg_cell.
module ilc_lg #(
   parameter int SIDE_W = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [ilc_pkg::VW-1:0]           in_v,
   input  logic [5:0]                       in_fb,
   input  logic [SIDE_W-1:0]                in_side,
   output logic                             out_valid,
   output logic signed [ilc_pkg::LGW-1:0]   out_lg,
   output logic [SIDE_W-1:0]                out_side
);
   import ilc_pkg::*;

   logic [VW-1:0]     nv   [NORM_STEPS+1];
   logic [5:0]        ncnt [NORM_STEPS+1];
   logic [5:0]        nfb  [NORM_STEPS+1];
   logic [SIDE_W-1:0] nside[NORM_STEPS+1];
   logic              nval [NORM_STEPS+1];

   logic [VW-1:0]     nv_ff   [NORM_STEPS];
   logic [5:0]        ncnt_ff [NORM_STEPS];
   logic [5:0]        nfb_ff  [NORM_STEPS];
   logic [SIDE_W-1:0] nside_ff[NORM_STEPS];
   logic              nval_ff [NORM_STEPS];

   assign nv[0]    = in_v;
   assign ncnt[0]  = '0;
   assign nfb[0]   = in_fb;
   assign nside[0] = in_side;
   assign nval[0]  = in_valid;

   for (genvar s = 0; s < NORM_STEPS; s++) begin : g_norm
      localparam int SH = 32 >> s;
      logic [VW-1:0] v_in;
      logic [5:0]    cnt_in;

      // shift left by SH when the top SH bits are clear
      always_comb begin
         if (nv[s][VW-1 -: SH] == '0) begin
            v_in   = nv[s] << SH;
            cnt_in = ncnt[s] + 6'(SH);
         end else begin
            v_in   = nv[s];
            cnt_in = ncnt[s];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nval_ff[s] <= 1'b0;
         end else if (en) begin
            nval_ff[s] <= nval[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nv_ff[s]    <= v_in;
            ncnt_ff[s]  <= cnt_in;
            nfb_ff[s]   <= nfb[s];
            nside_ff[s] <= nside[s];
         end
      end

      assign nv[s+1]    = nv_ff[s];
      assign ncnt[s+1]  = ncnt_ff[s];
      assign nfb[s+1]   = nfb_ff[s];
      assign nside[s+1] = nside_ff[s];
      assign nval[s+1]  = nval_ff[s];
   end

   lg_word_type       cw   [FRAC_STEPS+1];
   logic [SIDE_W-1:0] cside[FRAC_STEPS+1];
   logic              cval [FRAC_STEPS+1];

   always_comb begin
      cw[0].ip   = signed'(8'(VW - 1) - {2'b00, ncnt[NORM_STEPS]}
                           - {2'b00, nfb[NORM_STEPS]});
      cw[0].m    = nv[NORM_STEPS][VW-1 -: 32];
      cw[0].frac = '0;
   end
   assign cside[0] = nside[NORM_STEPS];
   assign cval[0]  = nval[NORM_STEPS];

   for (genvar k = 0; k < FRAC_STEPS; k++) begin : g_cell
      ilc_lg_cell #(.SIDE_W(SIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cval[k]),
         .in_word   (cw[k]),
         .in_side   (cside[k]),
         .out_valid (cval[k+1]),
         .out_word  (cw[k+1]),
         .out_side  (cside[k+1])
      );
   end

   assign out_valid = cval[FRAC_STEPS];
   assign out_lg    = {cw[FRAC_STEPS].ip, cw[FRAC_STEPS].frac};
   assign out_side  = cside[FRAC_STEPS];
endmodule

/* sv/ilc_ex.sv */
// Base-2 exponential unit: chain of root multiply cells, then the final shift.
// Depends on ilc_pkg and ilc_ex_cell.
module ilc_ex #(
   parameter int SIDE_W = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [ilc_pkg::TW-1:0]   in_t,
   input  logic [SIDE_W-1:0]               in_side,
   output logic                            out_valid,
   output logic [ilc_pkg::EW-1:0]          out_e,
   output logic [SIDE_W-1:0]               out_side
);
   import ilc_pkg::*;

   ex_word_type       cw   [FRAC_STEPS+1];
   logic [SIDE_W-1:0] cside[FRAC_STEPS+1];
   logic              cval [FRAC_STEPS+1];

   always_comb begin
      cw[0].n = in_t[TW-1:24];
      cw[0].f = in_t[23:0];
      cw[0].r = 32'd1 << 30;
   end
   assign cside[0] = in_side;
   assign cval[0]  = in_valid;

   for (genvar k = 0; k < FRAC_STEPS; k++) begin : g_cell
      ilc_ex_cell #(.K(k + 1), .SIDE_W(SIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cval[k]),
         .in_word   (cw[k]),
         .in_side   (cside[k]),
         .out_valid (cval[k+1]),
         .out_word  (cw[k+1]),
         .out_side  (cside[k+1])
      );
   end

   logic signed [NW:0] sft;
   logic [EW-1:0]      e_in, e_ff;
   logic [SIDE_W-1:0]  side_ff;
   logic               valid_ff;

   // scale by 2^(n+2); saturate high, flush low
   always_comb begin
      sft = (NW+1)'(cw[FRAC_STEPS].n) + (NW+1)'(2);
      if (sft > 8) begin
         e_in = EW'(1) << (EW - 1);
      end else if (sft >= 0) begin
         e_in = EW'(cw[FRAC_STEPS].r) << sft[3:0];
      end else if (sft <= -32) begin
         e_in = '0;
      end else begin
         e_in = EW'(cw[FRAC_STEPS].r >> 5'(-sft));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= cval[FRAC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff    <= e_in;
         side_ff <= cside[FRAC_STEPS];
      end
   end

   assign out_valid = valid_ff;
   assign out_e     = e_ff;
   assign out_side  = side_ff;
endmodule

/* sv/intensity_linearization_curve.sv */
// Intensity linearization curve: gamma, power and reverse-log curves in fixed point.
// One word per cycle sustained while the result is not stalled; the squaring and
// root-multiply cell chains are pipelined, one register per cell.
// A stalled result holds the whole pipe. Synchronous reset clears all valid
// bits and loads mode 0, inv_gamma 0x0A0000, inv_gain 0x010000.
// Depends on ilc_pkg, ilc_ex and ilc_lg.
module intensity_linearization_curve #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_intensity_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_intensity_out,
   output logic                   rsp_saturated,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [3:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import ilc_pkg::*;

   localparam int PW = SAMPLE_BITS + 26;

   // Per-word sideband riding along the pipe: raw sample, force-zero, product.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] x;
      logic                   zero;
      logic [YW-1:0]          y;
   } side_type;
   localparam int SW = $bits(side_type);

   // ---------------- configuration registers ----------------
   logic [2:0]  curve_mode_ff;
   logic [23:0] inv_gamma_ff;
   logic [19:0] inv_gain_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_mode_ff <= MODE_GAMMA;
         inv_gamma_ff  <= 24'h0A0000;
         inv_gain_ff   <= 20'h10000;
      end else if (wr_en) begin
         case (paddr[3:2])
            REG_MODE:  curve_mode_ff <= pwdata[2:0];
            REG_GAMMA: inv_gamma_ff  <= pwdata[23:0];
            REG_GAIN:  inv_gain_ff   <= pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_MODE:  prdata = {29'b0, curve_mode_ff};
         REG_GAMMA: prdata = {8'b0, inv_gamma_ff};
         REG_GAIN:  prdata = {12'b0, inv_gain_ff};
         default:   prdata = '0;
      endcase
   end

   logic is_pow, is_rev;
   always_comb begin
      is_pow = curve_mode_ff inside {MODE_SEP, MODE_LOC};
      is_rev = curve_mode_ff inside {MODE_REV0, MODE_REV1};
   end

   // Whole pipe advances when the output register is free or being drained.
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---------------- pre-scale: x * log2(e) for the power curves ----------
   logic [PW-1:0]         pre_prod;
   logic signed [TW-1:0]  pre_t_in, pre_t_ff;
   side_type              pre_side_in, pre_side_ff;
   logic                  pre_valid_ff;

   always_comb begin
      pre_prod = PW'(req_intensity_in) * PW'(LOG2E_Q24)
               + (PW'(1) << (SAMPLE_BITS - 1));
      pre_t_in = TW'(pre_prod >> SAMPLE_BITS);
      pre_side_in.x    = req_intensity_in;
      pre_side_in.zero = (req_intensity_in == '0);
      pre_side_in.y    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (en) begin
         pre_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_t_ff    <= pre_t_in;
         pre_side_ff <= pre_side_in;
      end
   end

   // ---------------- exp2 #1: e^x ----------------
   logic          a_valid;
   logic [EW-1:0] a_e;
   side_type      a_side;

   ilc_ex #(.SIDE_W(SW)) u_ex_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pre_valid_ff),
      .in_t      (pre_t_ff),
      .in_side   (pre_side_ff),
      .out_valid (a_valid),
      .out_e     (a_e),
      .out_side  (a_side)
   );

   // ---------------- subtract one, pick the log operand ----------------
   logic [VW-1:0] sub_v_in, sub_v_ff;
   logic [5:0]    sub_fb_in, sub_fb_ff;
   side_type      sub_side_in, sub_side_ff;
   logic          sub_valid_ff;

   always_comb begin
      sub_side_in = a_side;
      if (is_pow) begin
         sub_v_in  = VW'(a_e - (EW'(1) << 32));
         sub_fb_in = FB_WIDE;
         // drop to zero when e^x - 1 vanishes
         if (a_e <= (EW'(1) << 32)) begin
            sub_side_in.zero = 1'b1;
         end
      end else begin
         sub_v_in  = VW'(a_side.x);
         sub_fb_in = 6'(SAMPLE_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_valid_ff <= 1'b0;
      end else if (en) begin
         sub_valid_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sub_v_ff    <= sub_v_in;
         sub_fb_ff   <= sub_fb_in;
         sub_side_ff <= sub_side_in;
      end
   end

   // ---------------- log2 #1 ----------------
   logic                  b_valid;
   logic signed [LGW-1:0] b_lg;
   side_type              b_side;

   ilc_lg #(.SIDE_W(SW)) u_lg_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sub_valid_ff),
      .in_v      (sub_v_ff),
      .in_fb     (sub_fb_ff),
      .in_side   (sub_side_ff),
      .out_valid (b_valid),
      .out_lg    (b_lg),
      .out_side  (b_side)
   );

   // ---------------- scale the log by the exponent, round half up --------
   logic [23:0]           expo;
   logic signed [56:0]    mul_w;
   logic signed [TW-1:0]  mul_t_in, mul_t_ff;
   side_type              mul_side_ff;
   logic                  mul_valid_ff;

   always_comb begin
      case (curve_mode_ff)
         MODE_GAMMA: expo = inv_gamma_ff;
         MODE_SEP:   expo = E_SEP;
         MODE_LOC:   expo = E_LOC;
         MODE_REV0:  expo = B_REV0;
         MODE_REV1:  expo = B_REV1;
         default:    expo = '0;
      endcase
      mul_w    = 57'(b_lg) * signed'({33'b0, expo}) + 57'sd32768;
      mul_t_in = mul_w[TW+15:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_t_ff    <= mul_t_in;
         mul_side_ff <= b_side;
      end
   end

   // ---------------- exp2 #2 ----------------
   logic          c_valid;
   logic [EW-1:0] c_e;
   side_type      c_side;

   ilc_ex #(.SIDE_W(SW)) u_ex_c (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mul_valid_ff),
      .in_t      (mul_t_ff),
      .in_side   (mul_side_ff),
      .out_valid (c_valid),
      .out_e     (c_e),
      .out_side  (c_side)
   );

   // ---------------- gain / coefficient multiply ----------------
   logic [19:0]   coef;
   logic [60:0]   post_prod;
   logic [61:0]   post_rnd;
   logic [VW-1:0] post_q_in, post_q_ff;
   side_type      post_side_in, post_side_ff;
   logic          post_valid_ff;

   always_comb begin
      case (curve_mode_ff)
         MODE_GAMMA: coef = inv_gain_ff;
         MODE_SEP:   coef = C_SEP;
         MODE_LOC:   coef = C_LOC;
         MODE_REV0:  coef = A_REV0;
         MODE_REV1:  coef = A_REV1;
         default:    coef = '0;
      endcase
      post_prod = 61'(c_e) * 61'(coef);
      // reverse curves: q = 1 + a*p, Q.32
      post_rnd  = 62'(post_prod) + 62'd32768;
      post_q_in = VW'(post_rnd >> 16) + (VW'(1) << 32);
      post_side_in   = c_side;
      post_side_in.y = YW'(post_prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_valid_ff <= 1'b0;
      end else if (en) begin
         post_valid_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         post_q_ff    <= post_q_in;
         post_side_ff <= post_side_in;
      end
   end

   // ---------------- log2 #2 (reverse curves) ----------------
   logic                  d_valid;
   logic signed [LGW-1:0] d_lg;
   side_type              d_side;

   ilc_lg #(.SIDE_W(SW)) u_lg_d (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (post_valid_ff),
      .in_v      (post_q_ff),
      .in_fb     (FB_WIDE),
      .in_side   (post_side_ff),
      .out_valid (d_valid),
      .out_lg    (d_lg),
      .out_side  (d_side)
   );

   // ---------------- ln = log2 * ln2 for the reverse curves --------------
   logic [YW-1:0] m2_y_in, m2_y_ff;
   side_type      m2_side_ff;
   logic          m2_valid_ff;

   always_comb begin
      if (is_rev) begin
         m2_y_in = YW'(56'(unsigned'(d_lg)) * 56'(LN2_Q24));
      end else begin
         m2_y_in = d_side.y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m2_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_y_ff    <= m2_y_in;
         m2_side_ff <= d_side;
      end
   end

   // ---------------- round to sample width, clamp, output register -------
   logic [YW:0]            fin_sum;
   logic [YW:0]            fin_v;
   logic                   fin_over;
   logic [SAMPLE_BITS-1:0] out_in, out_ff;
   logic                   sat_in, sat_ff;

   always_comb begin
      fin_sum  = (YW+1)'(m2_y_ff) + ((YW+1)'(1) << (47 - SAMPLE_BITS));
      fin_v    = fin_sum >> (48 - SAMPLE_BITS);
      fin_over = (fin_v >> SAMPLE_BITS) != '0;
      if (fin_over) begin
         out_in = '1;
         sat_in = !is_rev;
      end else begin
         out_in = fin_v[SAMPLE_BITS-1:0];
         sat_in = 1'b0;
      end
      // unused modes pass the sample through; zero input or base gives zero
      if (curve_mode_ff > MODE_REV1) begin
         out_in = m2_side_ff.x;
         sat_in = 1'b0;
      end else if (m2_side_ff.zero) begin
         out_in = '0;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_intensity_out = out_ff;
   assign rsp_saturated     = sat_ff;
endmodule
